FILE: rtl/can2a_pkg.sv
// shared types, character codes and helpers for the can frame text encoder
package can2a_pkg;

	localparam int unsigned IdW     = 29;
	localparam int unsigned PgnW    = 18;
	localparam int unsigned BcdDig  = 6;
	localparam int unsigned StepW   = $clog2(PgnW + 1);
	localparam int unsigned InDataW = 104;
	localparam logic [7:0]  Pdu2Min = 8'd239;
	localparam logic [3:0]  MaxBytes = 4'd8;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_X      = 8'h78;

	typedef enum logic [2:0] {
		SEL_LIT,
		SEL_ID,
		SEL_PGN,
		SEL_COUNT,
		SEL_DATA
	} char_sel_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		char_sel_t  sel;
		logic [7:0] lit;
		logic [3:0] idx;
		logic       last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       in_ok;
		logic       is_ext;
		logic [2:0] id_top;
		logic [2:0] pgn_top;
		logic       bcd_done;
		logic [3:0] byte_count;
		logic       out_free;
	} dp_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CH_ZERO + {4'd0, v};
		end else begin
			c = 8'h41 + {4'd0, v} - 8'd10;
		end
		return c;
	endfunction

endpackage

FILE: rtl/can2a_dp.sv
// datapath: frame registers, pgn to decimal converter, character select, output register
module can2a_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [can2a_pkg::InDataW-1:0] s_tdata,
	input  logic [1:0]                   s_tuser,
	output logic [7:0]                   m_tdata,
	output logic                         m_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  can2a_pkg::ctrl_cmd_t         cmd,
	output can2a_pkg::dp_stat_t          stat
);
	import can2a_pkg::*;

	logic [IdW-1:0]      id_q;
	logic                ext_q;
	logic [3:0]          count_q;
	logic [63:0]         data_q;
	logic [PgnW-1:0]     bin_q;
	logic [BcdDig*4-1:0] bcd_q;
	logic [StepW-1:0]    step_q;
	logic [7:0]          char_q;
	logic                last_q;
	logic                ov_q;

	logic [IdW-1:0]      in_id;
	logic [PgnW-1:0]     in_pgn;
	logic [BcdDig*4-1:0] bcd_adj;
	logic [3:0]          dig;
	logic [31:0]         id32;
	logic [7:0]          byte_sel;
	logic [3:0]          nib;
	logic [7:0]          char_d;
	logic [2:0]          pgn_top;

	assign in_id = s_tdata[IdW-1:0];

	// pdu1 clears the pdu-specific byte
	always_comb begin
		if (in_id[23:16] > Pdu2Min) begin
			in_pgn = {in_id[25:24], in_id[23:16], in_id[15:8]};
		end else begin
			in_pgn = {in_id[25:24], in_id[23:16], 8'd0};
		end
	end

	// add-3 correction on each bcd digit before the shift
	always_comb begin
		for (int i = 0; i < BcdDig; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// highest nonzero decimal digit, zero prints as one digit
	always_comb begin
		pgn_top = 3'd0;
		for (int i = 0; i < BcdDig; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				pgn_top = i[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= StepW'(PgnW);
		end else if (step_q != '0) begin
			step_q <= step_q - StepW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q    <= in_id;
			ext_q   <= s_tuser[0];
			count_q <= s_tdata[IdW+3:IdW];
			data_q  <= s_tdata[IdW+67:IdW+4];
			bin_q   <= in_pgn;
			bcd_q   <= '0;
		end else if (step_q != '0) begin
			{bcd_q, bin_q} <= {bcd_adj[BcdDig*4-2:0], bin_q, 1'b0};
		end
	end

	assign id32 = {{(32-IdW){1'b0}}, id_q};
	assign byte_sel = data_q[cmd.idx[3:1]*8 +: 8];

	always_comb begin
		if (cmd.idx[2:0] < 3'(BcdDig)) begin
			dig = bcd_q[cmd.idx[2:0]*4 +: 4];
		end else begin
			dig = 4'd0;
		end
	end

	always_comb begin
		nib = 4'd0;
		unique case (cmd.sel)
			SEL_LIT: begin
				char_d = cmd.lit;
			end
			SEL_ID: begin
				nib    = id32[cmd.idx[2:0]*4 +: 4];
				char_d = hex_char(nib);
			end
			SEL_PGN: begin
				char_d = CH_ZERO + {4'd0, dig};
			end
			SEL_COUNT: begin
				char_d = CH_ZERO + {4'd0, count_q};
			end
			SEL_DATA: begin
				nib    = cmd.idx[0] ? byte_sel[7:4] : byte_sel[3:0];
				char_d = hex_char(nib);
			end
			default: begin
				char_d = cmd.lit;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= cmd.last;
		end
	end

	assign m_tdata  = char_q;
	assign m_tlast  = last_q;
	assign m_tvalid = ov_q;

	always_comb begin
		stat.in_ok      = !s_tuser[1] && (s_tdata[IdW+3:IdW] <= MaxBytes);
		stat.is_ext     = ext_q;
		stat.id_top     = ext_q ? 3'd7 : ((id_q[15:12] != 4'd0) ? 3'd3 : 3'd2);
		stat.pgn_top    = pgn_top;
		stat.bcd_done   = (step_q == '0);
		stat.byte_count = count_q;
		stat.out_free   = !ov_q || m_tready;
	end

endmodule

FILE: rtl/can2a_ctrl.sv
// controller: sequences the characters of one line
module can2a_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  can2a_pkg::dp_stat_t  stat,
	output can2a_pkg::ctrl_cmd_t cmd
);
	import can2a_pkg::*;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_OPEN   = 16'h0002,
		ST_TAG    = 16'h0004,
		ST_COMMA1 = 16'h0008,
		ST_ID     = 16'h0010,
		ST_LPAR   = 16'h0020,
		ST_PGN    = 16'h0040,
		ST_RPAR   = 16'h0080,
		ST_COMMA2 = 16'h0100,
		ST_COUNT  = 16'h0200,
		ST_COMMA3 = 16'h0400,
		ST_LBRK   = 16'h0800,
		ST_BYTE   = 16'h1000,
		ST_RBRK   = 16'h2000,
		ST_RBRACE = 16'h4000,
		ST_NL     = 16'h8000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [3:0] bidx_q, bidx_d;
	logic       go;

	assign go = stat.out_free;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		bidx_d   = bidx_q;
		cmd      = '0;
		cmd.sel  = SEL_LIT;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (stat.in_ok) begin
						state_d = ST_OPEN;
					end
				end
			end
			ST_OPEN: begin
				cmd.lit = CH_LBRACE;
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = 4'd0;
					state_d  = ST_TAG;
				end
			end
			ST_TAG: begin
				case (cnt_q[1:0])
					2'd0:    cmd.lit = stat.is_ext ? CH_E : CH_S;
					2'd1:    cmd.lit = stat.is_ext ? CH_X : CH_T;
					default: cmd.lit = stat.is_ext ? CH_T : CH_D;
				endcase
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = cnt_q + 4'd1;
					if (cnt_q == 4'd2) begin
						state_d = ST_COMMA1;
					end
				end
			end
			ST_COMMA1: begin
				cmd.lit = CH_COMMA;
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = {1'b0, stat.id_top};
					state_d  = ST_ID;
				end
			end
			ST_ID: begin
				cmd.sel = SEL_ID;
				cmd.idx = cnt_q;
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_d = stat.is_ext ? ST_LPAR : ST_COMMA2;
					end
				end
			end
			ST_LPAR: begin
				cmd.lit = CH_LPAR;
				// digit count is known only once the conversion has finished
				if (go && stat.bcd_done) begin
					cmd.emit = 1'b1;
					cnt_d    = {1'b0, stat.pgn_top};
					state_d  = ST_PGN;
				end
			end
			ST_PGN: begin
				cmd.sel = SEL_PGN;
				cmd.idx = cnt_q;
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_d = ST_RPAR;
					end
				end
			end
			ST_RPAR: begin
				cmd.lit = CH_RPAR;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_COMMA2;
				end
			end
			ST_COMMA2: begin
				cmd.lit = CH_COMMA;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.sel = SEL_COUNT;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_COMMA3;
				end
			end
			ST_COMMA3: begin
				cmd.lit = CH_COMMA;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_LBRK;
				end
			end
			ST_LBRK: begin
				cmd.lit = CH_LBRK;
				if (go) begin
					cmd.emit = 1'b1;
					cnt_d    = 4'd0;
					bidx_d   = 4'd0;
					state_d  = (stat.byte_count == 4'd0) ? ST_RBRK : ST_BYTE;
				end
			end
			ST_BYTE: begin
				// phase 0 high nibble, 1 low nibble, 2 separator
				if (cnt_q == 4'd2) begin
					cmd.lit = CH_COMMA;
				end else begin
					cmd.sel = SEL_DATA;
					cmd.idx = {bidx_q[2:0], (cnt_q == 4'd0)};
				end
				if (go) begin
					cmd.emit = 1'b1;
					if (cnt_q == 4'd0) begin
						cnt_d = 4'd1;
					end else if (cnt_q == 4'd1) begin
						if ((bidx_q + 4'd1) < stat.byte_count) begin
							cnt_d = 4'd2;
						end else begin
							state_d = ST_RBRK;
						end
					end else begin
						cnt_d  = 4'd0;
						bidx_d = bidx_q + 4'd1;
					end
				end
			end
			ST_RBRK: begin
				cmd.lit = CH_RBRK;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_RBRACE;
				end
			end
			ST_RBRACE: begin
				cmd.lit = CH_RBRACE;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_NL;
				end
			end
			ST_NL: begin
				cmd.lit  = CH_NL;
				cmd.last = 1'b1;
				if (go) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
			bidx_q  <= 4'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bidx_q  <= bidx_d;
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("character loaded into a full output register");
	a_pgn_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PGN) |-> stat.bcd_done)
		else $error("decimal digits used before conversion finished");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_IDLE || state_q == ST_OPEN))
		else $error("frame load left the controller in a wrong state");
	a_last_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("line end not followed by idle");
`endif

endmodule

FILE: rtl/can_frame_to_ascii_encoder_top.sv
// top level of the can frame to ascii line encoder
//
// input channel s_*: one received frame per item. s_tuser holds the frame
// kind (0 standard, 1 extended); s_tdata holds identifier, byte count and
// the eight payload bytes. output channel m_*: one ascii character per item,
// m_tlast set on the closing newline.
// a frame is taken only while the controller is idle, in the cycle after the
// previous line's newline has been loaded into the output register. a frame
// of invalid kind or with more than eight bytes is taken as well but
// gives no output.
// a valid frame gives 15 to 51 characters, one per cycle into the output
// register while m_tready stays high and the '(' does not wait; the first
// character is valid once the controller has left idle and loaded '{' into
// the output register. the pgn of an extended frame goes through an 18-step
// shift-and-add-3 converter started when the frame is taken; the '('
// character waits for it.
// m_tready low holds the output register and stops the controller; nothing
// is lost. reset empties the output register and returns the controller to
// idle; the frame registers need no reset.
module can_frame_to_ascii_encoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// identifier[28:0], byte_count[32:29], data0..data7 from bit 33 up, zero fill
	input  logic [can2a_pkg::InDataW-1:0] s_tdata,
	// frame_kind[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// text_char[7:0]
	output logic [7:0]                    m_tdata,
	output logic                          m_tlast
);
	import can2a_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	can2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	can2a_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
